FILE: hw/rtl/rbbe_pkg.sv
package rbbe_pkg;

  localparam int unsigned NumColours = 3;
  localparam int unsigned DutyW      = 7;
  localparam int unsigned CountW     = 16;
  localparam int unsigned PeriodW    = 8;
  localparam int unsigned ModeW      = 3;
  localparam int unsigned MaskW      = 3;
  localparam int unsigned PaddrW     = 4;
  localparam int unsigned PdataW     = 32;

  localparam logic [DutyW-1:0] DutyFull = DutyW'(100);
  localparam logic [MaskW-1:0] ColourKeep = MaskW'((1 << NumColours) - 1);

  typedef enum logic [ModeW-1:0] {
    LmOff        = 3'd0,
    LmOn         = 3'd1,
    LmBlink      = 3'd2,
    LmBreathe    = 3'd3,
    LmSymBreathe = 3'd4
  } mode_e;

  typedef enum logic {
    OpTick  = 1'b0,
    OpStart = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    RegMaxDuty    = 2'd0,
    RegMinDuty    = 2'd1,
    RegStepTicks  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [DutyW-1:0]   duty_top;
    logic [DutyW-1:0]   duty_bottom;
    logic [PeriodW-1:0] breathe_step_ticks;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [ModeW-1:0]   led_mode;
    logic [MaskW-1:0]   colour_mask;
    logic [PeriodW-1:0] blink_period;
    logic [CountW-1:0]  repeat_count;
  } item_t;

  typedef struct packed {
    logic [DutyW-1:0] red_duty;
    logic [DutyW-1:0] blue_duty;
    logic [DutyW-1:0] green_duty;
    logic             working;
    logic [ModeW-1:0] mode_now;
  } result_t;

  function automatic logic [DutyW-1:0] clamp_pct(input logic [DutyW-1:0] v);
    return (v > DutyFull) ? DutyFull : v;
  endfunction

  function automatic logic [PeriodW-1:0] at_least_one(input logic [PeriodW-1:0] v);
    return (v == '0) ? PeriodW'(1) : v;
  endfunction

endpackage

FILE: hw/rtl/rbbe_apb_regs.sv
module rbbe_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbbe_pkg::PaddrW-1:0]  paddr,
  input  logic [rbbe_pkg::PdataW-1:0]  pwdata,
  output logic [rbbe_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  output rbbe_pkg::cfg_t               cfg_o
);

  rbbe_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [1:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        rbbe_pkg::RegMaxDuty:   cfg_d.duty_top = pwdata[rbbe_pkg::DutyW-1:0];
        rbbe_pkg::RegMinDuty:   cfg_d.duty_bottom = pwdata[rbbe_pkg::DutyW-1:0];
        rbbe_pkg::RegStepTicks: cfg_d.breathe_step_ticks = pwdata[rbbe_pkg::PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rbbe_pkg::RegMaxDuty:   prdata = rbbe_pkg::PdataW'(cfg_q.duty_top);
      rbbe_pkg::RegMinDuty:   prdata = rbbe_pkg::PdataW'(cfg_q.duty_bottom);
      rbbe_pkg::RegStepTicks: prdata = rbbe_pkg::PdataW'(cfg_q.breathe_step_ticks);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_top           <= rbbe_pkg::DutyFull;
      cfg_q.duty_bottom        <= '0;
      cfg_q.breathe_step_ticks <= rbbe_pkg::PeriodW'(2);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/rbbe_engine.sv
module rbbe_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  rbbe_pkg::item_t   item_i,
  input  rbbe_pkg::cfg_t    cfg_i,
  output rbbe_pkg::result_t result_o
);

  rbbe_pkg::mode_e              mode_q, mode_d;
  logic [rbbe_pkg::MaskW-1:0]   colours_q, colours_d;
  logic [rbbe_pkg::DutyW-1:0]   duty_q, duty_d;
  logic [rbbe_pkg::DutyW-1:0]   shown_q, shown_d;
  logic                         rising_q, rising_d;
  logic [rbbe_pkg::CountW-1:0]  remaining_q, remaining_d;
  logic                         endless_q, endless_d;
  logic [rbbe_pkg::PeriodW-1:0] step_period_q, step_period_d;
  logic [rbbe_pkg::PeriodW-1:0] phase_q, phase_d;
  logic                         ticking_q, ticking_d;
  logic                         active_q, active_d;

  logic [rbbe_pkg::DutyW-1:0]   hi, lo;
  logic [rbbe_pkg::CountW-1:0]  rem_dec;
  logic [rbbe_pkg::PeriodW:0]   phase_inc;
  logic                         count_zero;
  logic [2:0][rbbe_pkg::DutyW-1:0] duty_out;

  assign hi         = rbbe_pkg::clamp_pct(cfg_i.duty_top);
  assign lo         = rbbe_pkg::clamp_pct(cfg_i.duty_bottom);
  assign rem_dec    = (remaining_q != '0) ? remaining_q - rbbe_pkg::CountW'(1) : remaining_q;
  assign phase_inc  = {1'b0, phase_q} + (rbbe_pkg::PeriodW+1)'(1);
  assign count_zero = (item_i.repeat_count == '0);

  always_comb begin
    mode_d        = mode_q;
    colours_d     = colours_q;
    duty_d        = duty_q;
    shown_d       = shown_q;
    rising_d      = rising_q;
    remaining_d   = remaining_q;
    endless_d     = endless_q;
    step_period_d = step_period_q;
    phase_d       = phase_q;
    ticking_d     = ticking_q;
    active_d      = active_q;

    if (item_i.op == rbbe_pkg::OpStart) begin
      shown_d   = '0;
      ticking_d = 1'b0;
      active_d  = 1'b0;
      phase_d   = '0;
      colours_d = item_i.colour_mask & rbbe_pkg::ColourKeep;
      mode_d    = (item_i.led_mode <= rbbe_pkg::ModeW'(rbbe_pkg::LmSymBreathe))
                  ? rbbe_pkg::mode_e'(item_i.led_mode) : rbbe_pkg::LmOff;
      case (mode_d)
        rbbe_pkg::LmOn: begin
          active_d = 1'b1;
          duty_d   = rbbe_pkg::DutyFull;
          shown_d  = rbbe_pkg::DutyFull;
        end
        rbbe_pkg::LmBlink: begin
          step_period_d = rbbe_pkg::at_least_one(item_i.blink_period);
          rising_d      = 1'b1;
          endless_d     = count_zero;
          remaining_d   = count_zero ? rbbe_pkg::CountW'(1) : item_i.repeat_count;
          duty_d        = '0;
          ticking_d     = 1'b1;
          active_d      = 1'b1;
        end
        rbbe_pkg::LmBreathe, rbbe_pkg::LmSymBreathe: begin
          step_period_d = rbbe_pkg::at_least_one(cfg_i.breathe_step_ticks);
          endless_d     = (mode_d == rbbe_pkg::LmBreathe) && count_zero;
          remaining_d   = count_zero ? rbbe_pkg::CountW'(1) : item_i.repeat_count;
          if ((mode_d == rbbe_pkg::LmSymBreathe) && count_zero) begin
            duty_d   = lo;
            rising_d = 1'b1;
          end else begin
            duty_d   = hi;
            rising_d = 1'b0;
          end
          ticking_d = 1'b1;
          active_d  = 1'b1;
        end
        default: begin
          duty_d = '0;
        end
      endcase
    end else if (ticking_q) begin
      if (mode_q == rbbe_pkg::LmOff) begin
        ticking_d = 1'b0;
        active_d  = 1'b0;
      end else begin
        if (phase_q == '0) begin
          case (mode_q)
            rbbe_pkg::LmBlink: begin
              if (rising_q) begin
                shown_d  = rbbe_pkg::DutyFull;
                rising_d = 1'b0;
              end else begin
                shown_d  = '0;
                rising_d = 1'b1;
                if (!endless_q) begin
                  remaining_d = rem_dec;
                end
              end
              duty_d = shown_d;
            end
            rbbe_pkg::LmBreathe, rbbe_pkg::LmSymBreathe: begin
              if (rising_q) begin
                duty_d = (duty_q < rbbe_pkg::DutyFull) ? duty_q + rbbe_pkg::DutyW'(1) : duty_q;
                if (duty_d >= hi) begin
                  rising_d = 1'b0;
                  if (mode_q == rbbe_pkg::LmSymBreathe) begin
                    remaining_d = rem_dec;
                  end
                end
              end else begin
                duty_d = (duty_q != '0) ? duty_q - rbbe_pkg::DutyW'(1) : duty_q;
                if (duty_d <= lo) begin
                  rising_d = 1'b1;
                  if ((mode_q == rbbe_pkg::LmSymBreathe) || !endless_q) begin
                    remaining_d = rem_dec;
                  end
                end
              end
              shown_d = duty_d;
            end
            default: ;
          endcase
          if (remaining_d == '0) begin
            mode_d = rbbe_pkg::LmOff;
          end
        end
        phase_d = (phase_inc >= {1'b0, step_period_q}) ? '0
                                                        : phase_inc[rbbe_pkg::PeriodW-1:0];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      duty_out[c] = colours_d[c] ? shown_d : '0;
    end
  end

  assign result_o.red_duty   = duty_out[0];
  assign result_o.blue_duty  = duty_out[1];
  assign result_o.green_duty = duty_out[2];
  assign result_o.working    = active_d;
  assign result_o.mode_now   = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= rbbe_pkg::LmOff;
      colours_q     <= '0;
      duty_q        <= '0;
      shown_q       <= '0;
      rising_q      <= 1'b1;
      remaining_q   <= '0;
      endless_q     <= 1'b0;
      step_period_q <= rbbe_pkg::PeriodW'(1);
      phase_q       <= '0;
      ticking_q     <= 1'b0;
      active_q      <= 1'b0;
    end else if (advance_i) begin
      mode_q        <= mode_d;
      colours_q     <= colours_d;
      duty_q        <= duty_d;
      shown_q       <= shown_d;
      rising_q      <= rising_d;
      remaining_q   <= remaining_d;
      endless_q     <= endless_d;
      step_period_q <= step_period_d;
      phase_q       <= phase_d;
      ticking_q     <= ticking_d;
      active_q      <= active_d;
    end
  end

endmodule

FILE: hw/rtl/rgb_led_blink_breathe_engine.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   op, led_mode, colour_mask, blink_period,
//                                                repeat_count
// out       output     out_valid_o / out_stall_i red/blue/green_duty, working, mode_now
// cfg       input      apb (psel, penable, ...)  duty_top, duty_bottom, breathe_step_ticks
//
// one item per cycle while out_stall_i is low; an item passes the input register,
// then the state update into the result register
// reset clears the input and result valid flags and returns the engine to off
// a stalled result holds the result register; the input register still takes
// one item, then in_stall_o rises until the result is taken
module rgb_led_blink_breathe_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [rbbe_pkg::ModeW-1:0]    led_mode_i,
  input  logic [rbbe_pkg::MaskW-1:0]    colour_mask_i,
  input  logic [rbbe_pkg::PeriodW-1:0]  blink_period_i,
  input  logic [rbbe_pkg::CountW-1:0]   repeat_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rbbe_pkg::DutyW-1:0]    red_duty_o,
  output logic [rbbe_pkg::DutyW-1:0]    blue_duty_o,
  output logic [rbbe_pkg::DutyW-1:0]    green_duty_o,
  output logic                          working_o,
  output logic [rbbe_pkg::ModeW-1:0]    mode_now_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbbe_pkg::PaddrW-1:0]   paddr,
  input  logic [rbbe_pkg::PdataW-1:0]   pwdata,
  output logic [rbbe_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  rbbe_pkg::cfg_t    cfg;
  rbbe_pkg::item_t   s1_item_q;
  logic              s1_valid_q;
  rbbe_pkg::result_t res_d, res_q;
  logic              out_valid_q;
  logic              advance;
  logic              in_take;

  rbbe_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance    = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  rbbe_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_item_q),
    .cfg_i     (cfg),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.op           <= op_i;
      s1_item_q.led_mode     <= led_mode_i;
      s1_item_q.colour_mask  <= colour_mask_i;
      s1_item_q.blink_period <= blink_period_i;
      s1_item_q.repeat_count <= repeat_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_duty_o   = res_q.red_duty;
  assign blue_duty_o  = res_q.blue_duty;
  assign green_duty_o = res_q.green_duty;
  assign working_o    = res_q.working;
  assign mode_now_o   = res_q.mode_now;

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("result register not loaded after an item advanced");

  a_stall_needs_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_mode_implies_working: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_now_o != rbbe_pkg::ModeW'(rbbe_pkg::LmOff))) |-> working_o)
    else $error("running mode reported without the working flag");

endmodule
